>>> design/cgte_pkg.sv
// ----------------------------------------------------------------------------
// cgte_pkg
// Shared sizes, request codes and status codes of the graph transpose engine.
// ----------------------------------------------------------------------------
package cgte_pkg;

  localparam int MAX_STATES       = 1024;
  localparam int MAX_EDGES        = 4096;
  localparam int MAX_PRED_ENTRIES = 5120;

  localparam int SW  = $clog2(MAX_STATES);           // state index
  localparam int SCW = $clog2(MAX_STATES + 1);       // state count
  localparam int EW  = $clog2(MAX_EDGES);            // edge index
  localparam int ECW = $clog2(MAX_EDGES + 1);        // edge count
  localparam int PW  = $clog2(MAX_PRED_ENTRIES);     // predecessor index
  localparam int PCW = $clog2(MAX_PRED_ENTRIES + 1); // predecessor count

  localparam int REQW = 3;
  localparam int STSW = 3;
  localparam int NUMW = 12;

  typedef logic [REQW-1:0] req_t;
  typedef logic [STSW-1:0] sts_t;

  localparam req_t REQ_ADD    = 3'd0;
  localparam req_t REQ_FINISH = 3'd1;
  localparam req_t REQ_BUILD  = 3'd2;
  localparam req_t REQ_READ   = 3'd3;
  localparam req_t REQ_FIND   = 3'd4;
  localparam req_t REQ_CLEAR  = 3'd5;

  localparam sts_t STS_OK        = 3'd0;
  localparam sts_t STS_OVERFLOW  = 3'd1;
  localparam sts_t STS_NOT_BUILT = 3'd2;
  localparam sts_t STS_RANGE     = 3'd3;
  localparam sts_t STS_NOT_FOUND = 3'd4;

endpackage

>>> design/csr_graph_transpose_engine.sv
// ----------------------------------------------------------------------------
// csr_graph_transpose_engine
// Sparse-row transition graph store with predecessor build and queries.
// ----------------------------------------------------------------------------
// Add edge, finish state, clear: the result is registered through ST_FIN after accept.
// Read predecessor: three dependent memory reads through ST_QA, ST_QB and ST_QC.
// Find successor: reads the row bounds, then scans the row edge by edge (edge memory read port).
// Build: clears the counts, then two RMW passes over the rows with a prefix sum between them.
// One transaction at a time; reset is synchronous, empties the graph, no sweep.

module csr_graph_transpose_engine
  import cgte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,  // req_type
  input  logic [39:0] in_tdata,  // succ_state, absorbing_flag, state_index, entry_number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser, // status
  output logic [39:0] out_tdata  // result_state, result_count, result_number
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_FIN    = 5'd1;
  localparam logic [4:0] ST_QA     = 5'd2;
  localparam logic [4:0] ST_QB     = 5'd3;
  localparam logic [4:0] ST_QC     = 5'd4;
  localparam logic [4:0] ST_FA     = 5'd5;
  localparam logic [4:0] ST_FB     = 5'd6;
  localparam logic [4:0] ST_FE     = 5'd7;
  localparam logic [4:0] ST_FC     = 5'd8;
  localparam logic [4:0] ST_BCLR   = 5'd9;
  localparam logic [4:0] ST_BROW   = 5'd10;
  localparam logic [4:0] ST_BROWD  = 5'd11;
  localparam logic [4:0] ST_BE     = 5'd12;
  localparam logic [4:0] ST_BT     = 5'd13;
  localparam logic [4:0] ST_BWR    = 5'd14;
  localparam logic [4:0] ST_BPFX   = 5'd15;
  localparam logic [4:0] ST_BPFXW  = 5'd16;

  // memories
  logic [ECW-1:0] row_mem  [0:MAX_STATES];
  logic [SW-1:0]  edge_mem [0:MAX_EDGES-1];
  logic           abs_mem  [0:MAX_STATES-1];
  logic [PCW-1:0] ps_mem   [0:MAX_STATES];
  logic [PCW-1:0] fp_mem   [0:MAX_STATES-1];
  logic [SW-1:0]  src_mem  [0:MAX_PRED_ENTRIES-1];

  logic           row_we;   logic [SCW-1:0] row_wa, row_ra; logic [ECW-1:0] row_wd, row_rd_r;
  logic           row_zero_r;
  logic           edge_we;  logic [EW-1:0]  edge_wa, edge_ra; logic [SW-1:0] edge_wd, edge_rd_r;
  logic           abs_we;   logic [SW-1:0]  abs_wa, abs_ra; logic abs_wd, abs_rd_r;
  logic           ps_we;    logic [SCW-1:0] ps_wa, ps_ra; logic [PCW-1:0] ps_wd, ps_rd_r;
  logic           fp_we;    logic [SW-1:0]  fp_wa, fp_ra; logic [PCW-1:0] fp_wd, fp_rd_r;
  logic           src_we;   logic [PW-1:0]  src_wa, src_ra; logic [SW-1:0] src_wd, src_rd_r;

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    row_rd_r   <= row_mem[row_ra];
    row_zero_r <= (row_ra == '0);
  end
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd_r <= edge_mem[edge_ra];
  end
  always_ff @(posedge clk) begin
    if (abs_we) abs_mem[abs_wa] <= abs_wd;
    abs_rd_r <= abs_mem[abs_ra];
  end
  always_ff @(posedge clk) begin
    if (ps_we) ps_mem[ps_wa] <= ps_wd;
    ps_rd_r <= ps_mem[ps_ra];
  end
  always_ff @(posedge clk) begin
    if (fp_we) fp_mem[fp_wa] <= fp_wd;
    fp_rd_r <= fp_mem[fp_ra];
  end
  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    src_rd_r <= src_mem[src_ra];
  end

  // control and working registers
  logic [4:0]      state_r, state_nxt;
  logic [SCW-1:0]  sc_r, sc_nxt;
  logic [ECW-1:0]  ec_r, ec_nxt;
  logic            built_r, built_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [SW-1:0]   succ_r, succ_nxt, st_r, st_nxt, dest_r, dest_nxt;
  logic [PCW-1:0]  num_r, num_nxt, a_r, a_nxt;
  logic [SCW-1:0]  s_r, s_nxt, k_r, k_nxt;
  logic [ECW-1:0]  start_r, start_nxt, end_r, end_nxt, e_r, e_nxt;
  logic            absq_r, absq_nxt, pass_r, pass_nxt;
  logic [PCW:0]    sum_r, sum_nxt;
  sts_t            res_sts_r, res_sts_nxt;
  logic [SW-1:0]   res_state_r, res_state_nxt;
  logic [PCW-1:0]  res_count_r, res_count_nxt;
  logic [NUMW-1:0] res_num_r, res_num_nxt;
  logic [2:0]      out_tuser_r, out_tuser_nxt;
  logic [39:0]     out_tdata_r, out_tdata_nxt;

  logic            in_acc;
  req_t            in_req;
  logic [SW-1:0]   in_succ, in_st;
  logic            in_flag;
  logic [PCW-1:0]  in_num;
  logic [ECW-1:0]  row_val;
  logic [PCW-1:0]  cnt;
  logic [PCW:0]    nsum;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_req     = in_tuser;
  assign in_succ    = in_tdata[9:0];
  assign in_flag    = in_tdata[10];
  assign in_st      = in_tdata[20:11];
  assign in_num     = in_tdata[33:21];
  assign row_val    = row_zero_r ? '0 : row_rd_r;
  assign cnt        = ps_rd_r - a_r;
  assign nsum       = sum_r + {1'b0, ps_rd_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt = state_r;   sc_nxt = sc_r;       ec_nxt = ec_r;
    built_nxt = built_r;   succ_nxt = succ_r;   st_nxt = st_r;
    dest_nxt = dest_r;     num_nxt = num_r;     a_nxt = a_r;
    s_nxt = s_r;           k_nxt = k_r;         start_nxt = start_r;
    end_nxt = end_r;       e_nxt = e_r;         absq_nxt = absq_r;
    pass_nxt = pass_r;     sum_nxt = sum_r;
    res_sts_nxt = res_sts_r;     res_state_nxt = res_state_r;
    res_count_nxt = res_count_r; res_num_nxt = res_num_r;
    out_tuser_nxt = out_tuser_r; out_tdata_nxt = out_tdata_r;
    out_valid_nxt = out_valid_r && !out_tready;

    row_we = 1'b0;  row_wa = '0; row_wd = '0; row_ra = '0;
    edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
    abs_we = 1'b0;  abs_wa = '0; abs_wd = 1'b0; abs_ra = '0;
    ps_we = 1'b0;   ps_wa = '0; ps_wd = '0; ps_ra = '0;
    fp_we = 1'b0;   fp_wa = '0; fp_wd = '0; fp_ra = '0;
    src_we = 1'b0;  src_wa = '0; src_wd = '0; src_ra = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          succ_nxt = in_succ; st_nxt = in_st; num_nxt = in_num;
          res_sts_nxt = STS_OK; res_state_nxt = '0;
          res_count_nxt = '0;   res_num_nxt = '0;
          state_nxt = ST_FIN;
          case (in_req)
            REQ_ADD: begin
              if (ec_r == ECW'(MAX_EDGES)) begin
                res_sts_nxt = STS_OVERFLOW;
              end else begin
                edge_we = 1'b1; edge_wa = ec_r[EW-1:0]; edge_wd = in_succ;
                ec_nxt = ec_r + 1'b1;
                built_nxt = 1'b0;
              end
            end
            REQ_FINISH: begin
              if (sc_r == SCW'(MAX_STATES)) begin
                res_sts_nxt = STS_OVERFLOW;
              end else begin
                abs_we = 1'b1; abs_wa = sc_r[SW-1:0]; abs_wd = in_flag;
                row_we = 1'b1; row_wa = sc_r + 1'b1; row_wd = ec_r;
                sc_nxt = sc_r + 1'b1;
                built_nxt = 1'b0;
              end
            end
            REQ_BUILD: begin
              k_nxt = '0;
              state_nxt = ST_BCLR;
            end
            REQ_READ: begin
              if (!built_r) begin
                res_sts_nxt = STS_NOT_BUILT;
              end else if ({1'b0, in_st} >= sc_r) begin
                res_sts_nxt = STS_RANGE;
              end else begin
                ps_ra = {1'b0, in_st};
                state_nxt = ST_QA;
              end
            end
            REQ_FIND: begin
              if ({1'b0, in_st} >= sc_r) begin
                res_sts_nxt = STS_RANGE;
              end else begin
                row_ra = {1'b0, in_st};
                abs_ra = in_st;
                state_nxt = ST_FA;
              end
            end
            REQ_CLEAR: begin
              sc_nxt = '0; ec_nxt = '0; built_nxt = 1'b0;
            end
            default: res_sts_nxt = STS_RANGE;
          endcase
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = res_sts_r;
          out_tdata_nxt = {5'd0, res_num_r, res_count_r, res_state_r};
          state_nxt = ST_IDLE;
        end
      end

      ST_QA: begin
        a_nxt = ps_rd_r;
        ps_ra = {1'b0, st_r} + 1'b1;
        state_nxt = ST_QB;
      end
      ST_QB: begin
        res_count_nxt = cnt;
        if (num_r >= cnt) begin
          res_sts_nxt = STS_RANGE;
          state_nxt = ST_FIN;
        end else begin
          src_ra = PW'(a_r + num_r);
          state_nxt = ST_QC;
        end
      end
      ST_QC: begin
        res_state_nxt = src_rd_r;
        state_nxt = ST_FIN;
      end

      ST_FA: begin
        start_nxt = row_val;
        absq_nxt = abs_rd_r;
        row_ra = {1'b0, st_r} + 1'b1;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        end_nxt = row_val;
        state_nxt = ST_FIN;
        if (absq_r) begin
          res_sts_nxt = (succ_r == st_r) ? STS_OK : STS_NOT_FOUND;
        end else if (start_r < row_val) begin
          e_nxt = start_r;
          state_nxt = ST_FE;
        end else begin
          res_sts_nxt = STS_NOT_FOUND;
        end
      end
      ST_FE: begin
        edge_ra = e_r[EW-1:0];
        state_nxt = ST_FC;
      end
      ST_FC: begin
        if (edge_rd_r == succ_r) begin
          res_num_nxt = NUMW'(e_r - start_r);
          state_nxt = ST_FIN;
        end else if (e_r + 1'b1 < end_r) begin
          e_nxt = e_r + 1'b1;
          state_nxt = ST_FE;
        end else begin
          res_sts_nxt = STS_NOT_FOUND;
          state_nxt = ST_FIN;
        end
      end

      ST_BCLR: begin
        ps_we = 1'b1; ps_wa = k_r; ps_wd = '0;
        if (k_r < SCW'(MAX_STATES)) begin
          fp_we = 1'b1; fp_wa = k_r[SW-1:0]; fp_wd = '0;
        end
        if (k_r == sc_r) begin
          s_nxt = '0; start_nxt = '0; pass_nxt = 1'b0;
          state_nxt = ST_BROW;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_BROW: begin
        if (s_r == sc_r) begin
          if (!pass_r && sc_r != '0) begin
            k_nxt = SCW'(1); sum_nxt = '0;
            state_nxt = ST_BPFX;
          end else begin
            built_nxt = 1'b1;
            state_nxt = ST_FIN;
          end
        end else begin
          row_ra = s_r + 1'b1;
          abs_ra = s_r[SW-1:0];
          state_nxt = ST_BROWD;
        end
      end
      ST_BROWD: begin
        end_nxt = row_val;
        absq_nxt = abs_rd_r;
        if (abs_rd_r) begin
          dest_nxt = s_r[SW-1:0];
          ps_ra = s_r + 1'b1;
          fp_ra = s_r[SW-1:0];
          state_nxt = ST_BWR;
        end else if (start_r < row_val) begin
          e_nxt = start_r;
          state_nxt = ST_BE;
        end else begin
          s_nxt = s_r + 1'b1; start_nxt = row_val;
          state_nxt = ST_BROW;
        end
      end
      ST_BE: begin
        edge_ra = e_r[EW-1:0];
        state_nxt = ST_BT;
      end
      ST_BT: begin
        if ({1'b0, edge_rd_r} < sc_r) begin
          dest_nxt = edge_rd_r;
          ps_ra = {1'b0, edge_rd_r} + 1'b1;
          fp_ra = edge_rd_r;
          state_nxt = ST_BWR;
        end else if (e_r + 1'b1 < end_r) begin
          e_nxt = e_r + 1'b1;
          state_nxt = ST_BE;
        end else begin
          s_nxt = s_r + 1'b1; start_nxt = end_r;
          state_nxt = ST_BROW;
        end
      end
      ST_BWR: begin
        if (!pass_r) begin
          ps_we = 1'b1; ps_wa = {1'b0, dest_r} + 1'b1; ps_wd = ps_rd_r + 1'b1;
        end else begin
          src_we = 1'b1; src_wa = fp_rd_r[PW-1:0]; src_wd = s_r[SW-1:0];
          fp_we = 1'b1; fp_wa = dest_r; fp_wd = fp_rd_r + 1'b1;
        end
        if (!absq_r && (e_r + 1'b1 < end_r)) begin
          e_nxt = e_r + 1'b1;
          state_nxt = ST_BE;
        end else begin
          s_nxt = s_r + 1'b1; start_nxt = end_r;
          state_nxt = ST_BROW;
        end
      end
      ST_BPFX: begin
        ps_ra = k_r;
        state_nxt = ST_BPFXW;
      end
      ST_BPFXW: begin
        ps_we = 1'b1; ps_wa = k_r; ps_wd = nsum[PCW-1:0];
        if (k_r < sc_r) begin
          fp_we = 1'b1; fp_wa = k_r[SW-1:0]; fp_wd = nsum[PCW-1:0];
        end
        sum_nxt = nsum;
        if (k_r == sc_r) begin
          if (nsum > (PCW+1)'(MAX_PRED_ENTRIES)) begin
            res_sts_nxt = STS_OVERFLOW;
            built_nxt = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            pass_nxt = 1'b1; s_nxt = '0; start_nxt = '0;
            state_nxt = ST_BROW;
          end
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = ST_BPFX;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sc_r        <= '0;
      ec_r        <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      ec_r        <= ec_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    succ_r <= succ_nxt;   st_r <= st_nxt;       dest_r <= dest_nxt;
    num_r <= num_nxt;     a_r <= a_nxt;         s_r <= s_nxt;
    k_r <= k_nxt;         start_r <= start_nxt; end_r <= end_nxt;
    e_r <= e_nxt;         absq_r <= absq_nxt;   pass_r <= pass_nxt;
    sum_r <= sum_nxt;
    res_sts_r <= res_sts_nxt;     res_state_r <= res_state_nxt;
    res_count_r <= res_count_nxt; res_num_r <= res_num_nxt;
    out_tuser_r <= out_tuser_nxt; out_tdata_r <= out_tdata_nxt;
  end

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction accepted while previous one in flight");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_CLEAR |=> sc_r == '0 && ec_r == '0 && !built_r)
    else $error("clear did not empty the graph");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= STS_NOT_FOUND)
    else $error("illegal status code");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= SCW'(MAX_STATES) && ec_r <= ECW'(MAX_EDGES))
    else $error("store count beyond capacity");
`endif

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csr_graph_transpose_engine. A directed table walks
// the empty-store, extreme and error cases. Random small graphs with random
// content and random noise requests follow. Results are checked with the row's
// answer where a row gives one, else with a local predecessor-list predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import cgte_pkg::*;
;

  localparam req_t REQ_BAD6 = 3'd6;
  localparam req_t REQ_BAD7 = 3'd7;

  typedef struct packed {
    sts_t             sts;
    logic [SW-1:0]    rstate;
    logic [PCW-1:0]   rcount;
    logic [NUMW-1:0]  rnum;
  } answer_t;

  typedef struct {
    req_t            req;
    logic [SW-1:0]   succ;
    logic            absf;
    logic [SW-1:0]   st;
    logic [PCW-1:0]  num;
    bit              typed;
    answer_t         ans;
  } row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [2:0]  out_tuser;
  logic [39:0] out_tdata;

  csr_graph_transpose_engine dut (.*);

  always #1 clk = ~clk;

  // graph mirror
  logic [PCW-1:0] g_row_start [0:MAX_STATES];
  logic [SW-1:0]  g_target    [0:MAX_EDGES-1];
  logic           g_absorb    [0:MAX_STATES-1];
  logic [PCW-1:0] g_pred_start[0:MAX_STATES];
  logic [SW-1:0]  g_pred_src  [0:MAX_PRED_ENTRIES-1];
  int             g_fill      [0:MAX_STATES-1];
  int             g_states, g_edges;
  bit             g_built;

  answer_t answer_q[$];
  int      n_err = 0;
  bit      calm = 0;
  bit      hold_go = 0;

  function automatic void graph_clear();
    g_states = 0;
    g_edges = 0;
    g_built = 0;
    g_row_start[0] = '0;
    for (int s = 0; s < MAX_STATES; s++) g_absorb[s] = 0;
  endfunction

  function automatic sts_t build_preds();
    int t;
    for (int s = 0; s <= MAX_STATES; s++) g_pred_start[s] = '0;
    for (int s = 0; s < g_states; s++) begin
      if (g_absorb[s]) g_pred_start[s+1]++;
      else for (int e = g_row_start[s]; e < g_row_start[s+1]; e++) begin
        t = g_target[e];
        if (t < g_states) g_pred_start[t+1]++;
      end
    end
    for (int s = 0; s < g_states; s++) g_pred_start[s+1] += g_pred_start[s];
    if (g_pred_start[g_states] > MAX_PRED_ENTRIES) begin
      g_built = 0;
      return STS_OVERFLOW;
    end
    for (int s = 0; s < g_states; s++) g_fill[s] = g_pred_start[s];
    for (int s = 0; s < g_states; s++) begin
      if (g_absorb[s]) g_pred_src[g_fill[s]++] = SW'(s);
      else for (int e = g_row_start[s]; e < g_row_start[s+1]; e++) begin
        t = g_target[e];
        if (t < g_states) g_pred_src[g_fill[t]++] = SW'(s);
      end
    end
    g_built = 1;
    return STS_OK;
  endfunction

  function automatic answer_t predict_answer(req_t req, logic [SW-1:0] succ, logic absf,
                                             logic [SW-1:0] st, logic [PCW-1:0] num);
    answer_t a;
    int cnt;
    a = '0;
    case (req)
      REQ_ADD: begin
        if (g_edges >= MAX_EDGES) a.sts = STS_OVERFLOW;
        else begin
          g_target[g_edges++] = succ;
          g_built = 0;
        end
      end
      REQ_FINISH: begin
        if (g_states >= MAX_STATES) a.sts = STS_OVERFLOW;
        else begin
          g_absorb[g_states] = absf;
          g_states++;
          g_row_start[g_states] = PCW'(g_edges);
          g_built = 0;
        end
      end
      REQ_BUILD: a.sts = build_preds();
      REQ_READ: begin
        if (!g_built) a.sts = STS_NOT_BUILT;
        else if (st >= g_states) a.sts = STS_RANGE;
        else begin
          cnt = g_pred_start[st+1] - g_pred_start[st];
          a.rcount = PCW'(cnt);
          if (num >= cnt) a.sts = STS_RANGE;
          else a.rstate = g_pred_src[g_pred_start[st] + num];
        end
      end
      REQ_FIND: begin
        if (st >= g_states) a.sts = STS_RANGE;
        else if (g_absorb[st]) begin
          if (succ != st) a.sts = STS_NOT_FOUND;
        end else begin
          a.sts = STS_NOT_FOUND;
          for (int e = g_row_start[st]; e < g_row_start[st+1]; e++) begin
            if (g_target[e] == succ) begin
              a.rnum = NUMW'(e - g_row_start[st]);
              a.sts = STS_OK;
              break;
            end
          end
        end
      end
      REQ_CLEAR: graph_clear();
      default: a.sts = STS_RANGE;
    endcase
    return a;
  endfunction

  // one transaction; valid stays high into the next call unless a gap is drawn
  task automatic send(req_t req, logic [SW-1:0] succ, logic absf, logic [SW-1:0] st,
                      logic [PCW-1:0] num, bit typed = 0, answer_t ans = '0);
    answer_t p;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {6'b0, num, st, absf, succ};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_answer(req, succ, absf, st, num);
    answer_q.push_back(typed ? ans : p);
    if (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_rand_noise();
    send(req_t'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[9:0], out_tdata[22:10], out_tdata[34:23]};
      if (answer_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h", got);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch sts %0d/%0d state %0d/%0d count %0d/%0d num %0d/%0d",
                     want.sts, got.sts, want.rstate, got.rstate,
                     want.rcount, got.rcount, want.rnum, got.rnum);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_go = 0;
      end
      out_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  row_t dir_tab[$];

  task automatic add_row(req_t req, int succ, int absf, int st, int num,
                         bit typed = 0, sts_t sts = STS_OK);
    row_t r;
    r.req = req; r.succ = SW'(succ); r.absf = absf[0]; r.st = SW'(st); r.num = PCW'(num);
    r.typed = typed;
    r.ans = '0;
    r.ans.sts = sts;
    dir_tab.push_back(r);
  endtask

  initial begin
    int ns, ne, nq;
    graph_clear();
    add_row(REQ_READ,   0,    0, 0,    0,    1, STS_NOT_BUILT);
    add_row(REQ_FIND,   0,    0, 0,    0,    1, STS_RANGE);
    add_row(REQ_BAD6,   1023, 1, 1023, 8191, 1, STS_RANGE);
    add_row(REQ_BAD7,   0,    0, 0,    0,    1, STS_RANGE);
    add_row(REQ_BUILD,  0,    0, 0,    0,    1, STS_OK);
    add_row(REQ_READ,   0,    0, 0,    0,    1, STS_RANGE);
    add_row(REQ_ADD,    1023, 0, 0,    0,    1, STS_OK);
    add_row(REQ_ADD,    0,    0, 0,    0,    1, STS_OK);
    add_row(REQ_ADD,    1,    0, 0,    0,    1, STS_OK);
    add_row(REQ_FINISH, 0,    0, 0,    0,    1, STS_OK);
    add_row(REQ_FINISH, 0,    1, 0,    0,    1, STS_OK);
    add_row(REQ_ADD,    1,    0, 0,    0,    1, STS_OK);
    add_row(REQ_READ,   0,    0, 0,    0,    1, STS_NOT_BUILT);
    add_row(REQ_BUILD,  0,    0, 0,    0,    1, STS_OK);
    add_row(REQ_READ,   0,    0, 0,    0);
    add_row(REQ_READ,   0,    0, 1,    0);
    add_row(REQ_READ,   0,    0, 1,    1);
    add_row(REQ_READ,   0,    0, 1,    8191);
    add_row(REQ_READ,   0,    0, 1023, 0,    1, STS_RANGE);
    add_row(REQ_FIND,   1,    0, 0,    0);
    add_row(REQ_FIND,   1023, 0, 0,    0);
    add_row(REQ_FIND,   1,    0, 1,    0);
    add_row(REQ_FIND,   0,    0, 1,    0);
    add_row(REQ_FIND,   5,    0, 0,    0);
    add_row(REQ_CLEAR,  0,    0, 0,    0,    1, STS_OK);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send(dir_tab[i].req, dir_tab[i].succ, dir_tab[i].absf, dir_tab[i].st,
           dir_tab[i].num, dir_tab[i].typed, dir_tab[i].ans);

    hold_go = 1;
    for (int g = 0; g < 24; g++) begin
      calm = (g >= 10 && g < 16);
      if (g == 20) begin
        in_tvalid <= 1'b0;
        wait (answer_q.size() == 0);
        @(posedge clk);
      end
      send(REQ_CLEAR, 0, 0, 0, 0);
      ns = $urandom_range(1, 12);
      for (int s = 0; s < ns; s++) begin
        ne = $urandom_range(0, 4);
        for (int k = 0; k < ne; k++)
          send(REQ_ADD, ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, ns + 1),
               0, 0, 0);
        if ($urandom_range(5) == 0) send_rand_noise();
        send(REQ_FINISH, 0, $urandom_range(3) == 0, 0, 0);
      end
      if ($urandom_range(3) == 0) send(REQ_ADD, $urandom_range(0, ns), 0, 0, 0);
      if ($urandom_range(7) != 0) send(REQ_BUILD, 0, 0, 0, 0);
      nq = $urandom_range(4, 14);
      for (int k = 0; k < nq; k++) begin
        case ($urandom_range(4))
          0, 1: send(REQ_READ, 0, 0, $urandom_range(0, ns), $urandom_range(0, 4));
          2, 3: send(REQ_FIND, $urandom_range(0, ns + 1), 0, $urandom_range(0, ns), 0);
          default: send_rand_noise();
        endcase
      end
    end
    calm = 0;
    in_tvalid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (100) @(posedge clk);
    if (n_err == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

endmodule
